[src/rwrc_pkg.sv]
package rwrc_pkg;

  // configuration register indexes
  localparam int unsigned CfgIdxW = 3;
  localparam logic [CfgIdxW-1:0] CFG_PANEL_WIDTH  = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_PANEL_HEIGHT = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_START_SIZE   = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_ANCHOR_RIGHT = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_OPEN_MODE    = 3'd4;
  localparam logic [CfgIdxW-1:0] CFG_OPEN_DUR     = 3'd5;
  localparam logic [CfgIdxW-1:0] CFG_CLOSE_DUR    = 3'd6;

  // reset values
  localparam logic [9:0] PANEL_WIDTH_RST  = 10'd160;
  localparam logic [9:0] PANEL_HEIGHT_RST = 10'd240;
  localparam logic [9:0] START_SIZE_RST   = 10'd30;
  localparam logic [9:0] OPEN_DUR_RST     = 10'd150;
  localparam logic [9:0] CLOSE_DUR_RST    = 10'd100;

  // divider sizes: dividend holds cube plus square, divisor holds a square
  localparam int unsigned DivNW = 31;
  localparam int unsigned DivDW = 20;
  localparam int unsigned DivCntW = 5;

  typedef struct packed {
    logic             start;
    logic [DivNW-1:0] dividend;
    logic [DivDW-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             busy;
    logic             done;
    logic [DivNW-1:0] quotient;
  } div_rsp_t;

  // floor(sqrt(a)) for a corner radius of at most 15
  function automatic logic [3:0] isqrt_small(input logic [7:0] a);
    logic [3:0] s;
    s = 4'd0;
    for (int k = 1; k < 16; k++) begin
      if (8'(k * k) <= a) begin
        s = 4'(k);
      end
    end
    return s;
  endfunction

  // window size from the scaled offset, clamped to start, panel and max size
  function automatic logic [9:0] size_calc(input logic [9:0] full,
                                           input logic [9:0] start,
                                           input logic [9:0] q,
                                           input logic opening,
                                           input logic signed [12:0] max_dim);
    logic signed [12:0] diff;
    logic signed [12:0] qs;
    logic signed [12:0] w;
    diff = $signed({3'b000, full}) - $signed({3'b000, start});
    qs = (diff < 0) ? -$signed({3'b000, q}) : $signed({3'b000, q});
    w = opening ? ($signed({3'b000, start}) + qs) : ($signed({3'b000, full}) - qs);
    if (w < $signed({3'b000, start})) w = $signed({3'b000, start});
    if (w > $signed({3'b000, full})) w = $signed({3'b000, full});
    if (w > max_dim) w = max_dim;
    if (w < 0) w = 13'sd0;
    return w[9:0];
  endfunction

endpackage

[src/rwrc_div.sv]
module rwrc_div import rwrc_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_req_t req_i,
  output div_rsp_t rsp_o
);

  logic [DivNW-1:0]   quo_q;
  logic [DivDW-1:0]   rem_q;
  logic [DivDW-1:0]   dvs_q;
  logic [DivCntW-1:0] cnt_q;
  logic               busy_q;
  logic               done_q;

  logic [DivDW:0]   rem_sh;
  logic             ge;
  logic [DivDW-1:0] rem_d;

  // restoring division, one quotient bit per cycle
  always_comb begin
    rem_sh = {rem_q, quo_q[DivNW-1]};
    ge = rem_sh >= {1'b0, dvs_q};
    rem_d = ge ? DivDW'(rem_sh - {1'b0, dvs_q}) : rem_sh[DivDW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        rem_q  <= '0;
        quo_q  <= req_i.dividend;
        dvs_q  <= req_i.divisor;
        cnt_q  <= '0;
        busy_q <= 1'b1;
      end else if (busy_q) begin
        rem_q <= rem_d;
        quo_q <= {quo_q[DivNW-2:0], ge};
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == DivCntW'(DivNW - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign rsp_o.busy = busy_q;
  assign rsp_o.done = done_q;
  assign rsp_o.quotient = quo_q;

endmodule

[src/rounded_window_reveal_compositor_unit.sv]
// Rounded window reveal compositor.
// Input stream s_axis: tuser is the action (0 frame update, 1 pixel), tdata carries
// elapsed_ms, pixel_x, pixel_y, background_pixel and panel_pixel. Every request gives
// exactly one result on m_axis: out_pixel, window_width, window_height, finished.
// Configuration is written through cfg_valid_i/cfg_index_i/cfg_data_i, always ready;
// write only while no request is in flight. Unknown indexes are dropped.
// One request at a time. A pixel result is loaded from ST_PIX once the output register
// is free. A frame update runs a sequencer over one shared 20x10 multiplier and one
// bit-serial divider. Opening runs three multiplies and the ease-out quotient, then
// the width and height quotients; closing runs the width and height quotients only.
// The next request is taken once the result loads. The result sits in an output
// register; the next request is accepted while it waits, and the block holds its
// finished result until m_axis_tready frees the register. Reset restores the register
// defaults and sets the window to the start size.
module rounded_window_reveal_compositor_unit import rwrc_pkg::*; #(
  parameter int unsigned CORNER_RADIUS = 5,
  parameter int unsigned MAX_DIM       = 1023
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               s_axis_tvalid,
  output logic               s_axis_tready,
  // elapsed_ms, pixel_x, pixel_y, background_pixel, panel_pixel, zero fill
  input  logic [71:0]        s_axis_tdata,
  // action
  input  logic               s_axis_tuser,
  output logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  // out_pixel, window_width, window_height, finished, zero fill
  output logic [39:0]        m_axis_tdata,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [9:0]         cfg_data_i
);

  localparam int unsigned RW = $clog2(CORNER_RADIUS + 2);
  localparam logic [7:0] RadSq = 8'(CORNER_RADIUS * CORNER_RADIUS);
  localparam logic signed [12:0] Rad = 13'(CORNER_RADIUS);
  localparam logic signed [12:0] MaxDimS = 13'(MAX_DIM);

  typedef enum logic [3:0] {
    ST_IDLE, ST_PIX, ST_MDD, ST_MD3, ST_MDUR, ST_PGO, ST_PWAIT,
    ST_MW, ST_WGO, ST_WWAIT, ST_MH, ST_HGO, ST_HWAIT, ST_FOUT
  } state_e;

  state_e state_q;

  logic [9:0] pw_q, ph_q, start_q, odur_q, cdur_q;
  logic       anchor_q, open_q;
  logic [9:0] cur_w_q, cur_h_q;

  logic [9:0]  x_q, y_q;
  logic [15:0] bg_q, fg_q;
  logic [9:0]  dur_q, d_q, p_q, qw_q;
  logic        opening_q, fin_q;
  logic [29:0] prod_q, d3_q;

  logic        out_valid_q;
  logic [39:0] out_data_q;

  div_req_t div_req;
  div_rsp_t div_rsp;

  rwrc_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // ---------------- configuration ----------------
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pw_q     <= PANEL_WIDTH_RST;
      ph_q     <= PANEL_HEIGHT_RST;
      start_q  <= START_SIZE_RST;
      anchor_q <= 1'b0;
      open_q   <= 1'b1;
      odur_q   <= OPEN_DUR_RST;
      cdur_q   <= CLOSE_DUR_RST;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_PANEL_WIDTH:  pw_q     <= cfg_data_i;
        CFG_PANEL_HEIGHT: ph_q     <= cfg_data_i;
        CFG_START_SIZE:   start_q  <= cfg_data_i;
        CFG_ANCHOR_RIGHT: anchor_q <= cfg_data_i[0];
        CFG_OPEN_MODE:    open_q   <= cfg_data_i[0];
        CFG_OPEN_DUR:     odur_q   <= cfg_data_i;
        CFG_CLOSE_DUR:    cdur_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // ---------------- request unpacking ----------------
  logic [15:0] in_el;
  logic [9:0]  in_dur_raw, in_dur, in_v;
  logic        s_acc, out_free, out_load;

  assign s_axis_tready = (state_q == ST_IDLE);
  assign s_acc = s_axis_tvalid && s_axis_tready;
  assign out_free = !out_valid_q || m_axis_tready;
  assign out_load = ((state_q == ST_PIX) || (state_q == ST_FOUT)) && out_free;

  always_comb begin
    in_el = s_axis_tdata[15:0];
    in_dur_raw = open_q ? odur_q : cdur_q;
    in_dur = (in_dur_raw == 10'd0) ? 10'd1 : in_dur_raw;
    in_v = (in_el > {6'd0, in_dur}) ? in_dur : in_el[9:0];
  end

  // ---------------- shared multiplier ----------------
  logic [9:0]  mag_w, mag_h;
  logic [19:0] mul_a;
  logic [9:0]  mul_b;
  logic [29:0] mul_p;

  assign mag_w = (pw_q >= start_q) ? (pw_q - start_q) : (start_q - pw_q);
  assign mag_h = (ph_q >= start_q) ? (ph_q - start_q) : (start_q - ph_q);
  assign mul_p = 30'(mul_a) * 30'(mul_b);

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      ST_MDD: begin
        mul_a = {10'd0, d_q};
        mul_b = d_q;
      end
      ST_MD3: begin
        mul_a = prod_q[19:0];
        mul_b = d_q;
      end
      ST_MDUR: begin
        mul_a = {10'd0, dur_q};
        mul_b = dur_q;
      end
      ST_MW: begin
        mul_a = {10'd0, mag_w};
        mul_b = p_q;
      end
      ST_MH: begin
        mul_a = {10'd0, mag_h};
        mul_b = p_q;
      end
      default: ;
    endcase
  end

  // ---------------- divider requests ----------------
  always_comb begin
    div_req.start = 1'b0;
    div_req.dividend = DivNW'(prod_q);
    div_req.divisor = DivDW'(dur_q);
    case (state_q)
      ST_PGO: begin
        // ceil of the cube of the remaining time over the square of the duration
        div_req.start = 1'b1;
        div_req.dividend = DivNW'(d3_q) + DivNW'(prod_q) - DivNW'(1);
        div_req.divisor = prod_q[DivDW-1:0];
      end
      ST_WGO, ST_HGO: div_req.start = 1'b1;
      default: ;
    endcase
  end

  // ---------------- pixel test ----------------
  logic signed [12:0] ws, hs, xs, ys, dy_full, cut, rx0, rx1, ox;
  logic [RW-1:0]      dy;
  logic [3:0]         sq;
  logic               in_area, in_win;
  logic [15:0]        pix;

  always_comb begin
    ws = $signed({3'b000, cur_w_q});
    hs = $signed({3'b000, cur_h_q});
    xs = $signed({3'b000, x_q});
    ys = $signed({3'b000, y_q});
    in_area = (cur_w_q != 10'd0) && (cur_h_q != 10'd0) && (y_q < cur_h_q) &&
              (y_q < ph_q) && (x_q < pw_q);
    // distance into the corner band, top or bottom
    if (ys < Rad) begin
      dy_full = Rad - ys;
    end else if (ys + Rad >= hs) begin
      dy_full = ys + Rad + 13'sd1 - hs;
    end else begin
      dy_full = 13'sd0;
    end
    dy = dy_full[RW-1:0];
    sq = isqrt_small(RadSq - 8'(8'(dy) * 8'(dy)));
    cut = Rad - $signed({9'd0, sq});
    rx1 = ws - 13'sd1 - cut;
    rx0 = (cut > rx1) ? rx1 : cut;
    ox = anchor_q ? ($signed({3'b000, pw_q}) - ws) : 13'sd0;
    in_win = in_area && (xs >= ox + rx0) && (xs <= ox + rx1);
    pix = in_win ? fg_q : bg_q;
  end

  // ---------------- sequencer ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      cur_w_q     <= START_SIZE_RST;
      cur_h_q     <= START_SIZE_RST;
    end else begin
      if (out_valid_q && m_axis_tready && !out_load) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (s_acc) begin
            x_q       <= s_axis_tdata[25:16];
            y_q       <= s_axis_tdata[35:26];
            bg_q      <= s_axis_tdata[51:36];
            fg_q      <= s_axis_tdata[67:52];
            dur_q     <= in_dur;
            d_q       <= in_dur - in_v;
            p_q       <= in_v;
            opening_q <= open_q;
            fin_q     <= (in_el >= {6'd0, in_dur});
            if (s_axis_tuser) begin
              state_q <= ST_PIX;
            end else if (open_q) begin
              state_q <= ST_MDD;
            end else begin
              state_q <= ST_MW;
            end
          end
        end
        ST_PIX: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            out_data_q  <= {3'd0, 1'b0, cur_h_q, cur_w_q, pix};
            state_q     <= ST_IDLE;
          end
        end
        ST_MDD: begin
          prod_q  <= mul_p;
          state_q <= ST_MD3;
        end
        ST_MD3: begin
          prod_q  <= mul_p;
          state_q <= ST_MDUR;
        end
        ST_MDUR: begin
          d3_q    <= prod_q;
          prod_q  <= mul_p;
          state_q <= ST_PGO;
        end
        ST_PGO: state_q <= ST_PWAIT;
        ST_PWAIT: begin
          if (div_rsp.done) begin
            p_q     <= dur_q - div_rsp.quotient[9:0];
            state_q <= ST_MW;
          end
        end
        ST_MW: begin
          prod_q  <= mul_p;
          state_q <= ST_WGO;
        end
        ST_WGO: state_q <= ST_WWAIT;
        ST_WWAIT: begin
          if (div_rsp.done) begin
            qw_q    <= div_rsp.quotient[9:0];
            state_q <= ST_MH;
          end
        end
        ST_MH: begin
          prod_q  <= mul_p;
          state_q <= ST_HGO;
        end
        ST_HGO: state_q <= ST_HWAIT;
        ST_HWAIT: begin
          if (div_rsp.done) begin
            cur_w_q <= size_calc(pw_q, start_q, qw_q, opening_q, MaxDimS);
            cur_h_q <= size_calc(ph_q, start_q, div_rsp.quotient[9:0], opening_q, MaxDimS);
            state_q <= ST_FOUT;
          end
        end
        ST_FOUT: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            out_data_q  <= {3'd0, fin_q, cur_h_q, cur_w_q, 16'd0};
            state_q     <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata = out_data_q;

  // ---------------- assertions ----------------
  a_div_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_req.start |-> !div_rsp.busy)
    else $error("divider started while busy");

  a_div_done_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_rsp.done |-> (state_q == ST_PWAIT || state_q == ST_WWAIT || state_q == ST_HWAIT))
    else $error("divider result with no sequencer waiting");

  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_acc |=> !s_axis_tready)
    else $error("request accepted while one is in flight");

  a_size_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FOUT) |-> ({3'b000, cur_w_q} <= 13'(MAX_DIM) &&
                             {3'b000, cur_h_q} <= 13'(MAX_DIM)))
    else $error("window size above limit");

  a_result_on_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == ST_PIX || state_q == ST_FOUT) && out_free) |=> out_valid_q)
    else $error("finished request produced no result");

endmodule

[sim/rwrc_reveal_checker.sv]
`timescale 1ns / 100ps

module rwrc_reveal_checker import rwrc_pkg::*; #(
  parameter int unsigned CORNER_RADIUS = 5,
  parameter int unsigned MAX_DIM       = 1023
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               s_axis_tvalid,
  input  logic               s_axis_tready,
  input  logic [71:0]        s_axis_tdata,
  input  logic               s_axis_tuser,
  input  logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  input  logic [39:0]        m_axis_tdata,
  input  logic               cfg_valid_i,
  input  logic               cfg_ready_o,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [9:0]         cfg_data_i,
  output int                 pending_o,
  output int                 fail_cnt_o
);

  localparam logic ActFrame = 1'b0;

  // highest field first, matching the result bus from bit 36 down
  typedef struct packed {
    logic        done;
    logic [9:0]  height;
    logic [9:0]  width;
    logic [15:0] pixel;
  } reveal_result_t;

  logic [9:0] panel_w, panel_h, start_sz, open_dur, close_dur;
  logic       anchor_r, opening;
  logic [9:0] win_w, win_h;

  reveal_result_t awaited_results[$];
  reveal_result_t want, got;
  int             errors;

  function automatic logic [9:0] eased_size(input logic [9:0] full_sz, input logic [9:0] start_v,
                                            input longint prog, input longint dur,
                                            input bit grow);
    longint f, s0, w;
    f  = full_sz;
    s0 = start_v;
    // signed division, truncating toward zero
    w = (f - s0) * prog / dur;
    w = grow ? s0 + w : f - w;
    if (w < s0) w = s0;
    if (w > f) w = f;
    if (w > longint'(MAX_DIM)) w = longint'(MAX_DIM);
    if (w < 0) w = 0;
    return 10'(w);
  endfunction

  // updates the window size and returns the frame result
  function automatic reveal_result_t advance_frame(input logic [15:0] elapsed);
    longint dur, el, v, p, rem, sq;
    reveal_result_t res;
    dur = opening ? open_dur : close_dur;
    if (dur == 0) dur = 1;
    el = elapsed;
    v  = (el > dur) ? dur : el;
    if (opening) begin
      // cubic ease-out with the ceiling taken exactly
      rem = dur - v;
      sq  = dur * dur;
      p   = dur - (rem * rem * rem + sq - 1) / sq;
    end else begin
      p = v;
    end
    win_w = eased_size(panel_w, start_sz, p, dur, opening);
    win_h = eased_size(panel_h, start_sz, p, dur, opening);
    res.pixel  = '0;
    res.width  = win_w;
    res.height = win_h;
    res.done   = (el >= dur);
    return res;
  endfunction

  function automatic reveal_result_t composite(input logic [9:0] px, input logic [9:0] py,
                                               input logic [15:0] bg, input logic [15:0] fg);
    longint x, y, w, h, pw, ph, r, rx0, rx1, dy, s, a, ox;
    bit shown;
    reveal_result_t res;
    x  = px;
    y  = py;
    w  = win_w;
    h  = win_h;
    pw = panel_w;
    ph = panel_h;
    r  = CORNER_RADIUS;
    shown = 1'b0;
    if (w > 0 && h > 0 && y < h && y < ph && x < pw) begin
      rx0 = 0;
      rx1 = w - 1;
      dy  = 0;
      if (y < r) dy = r - y;
      else if (y >= h - r) dy = y - (h - 1 - r);
      if (dy > 0) begin
        a = r * r - dy * dy;
        s = 0;
        while ((s + 1) * (s + 1) <= a) s++;
        rx0 = r - s;
        rx1 = w - 1 - (r - s);
      end
      if (rx0 < 0) rx0 = 0;
      if (rx1 > w - 1) rx1 = w - 1;
      if (rx0 > rx1) rx0 = rx1;
      ox = anchor_r ? (pw - w) : 0;
      shown = (x >= ox + rx0) && (x <= ox + rx1);
    end
    res.pixel  = shown ? fg : bg;
    res.width  = win_w;
    res.height = win_h;
    res.done   = 1'b0;
    return res;
  endfunction

  task automatic check_field(input string what, input int unsigned exp_v,
                             input int unsigned act_v);
    if (exp_v != act_v) begin
      $display("%0t: %s expected %0d got %0d", $time, what, exp_v, act_v);
      errors++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      panel_w   = PANEL_WIDTH_RST;
      panel_h   = PANEL_HEIGHT_RST;
      start_sz  = START_SIZE_RST;
      anchor_r  = 1'b0;
      opening   = 1'b1;
      open_dur  = OPEN_DUR_RST;
      close_dur = CLOSE_DUR_RST;
      win_w     = START_SIZE_RST;
      win_h     = START_SIZE_RST;
      awaited_results.delete();
      errors = 0;
      pending_o  <= 0;
      fail_cnt_o <= 0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          CFG_PANEL_WIDTH:  panel_w   = cfg_data_i;
          CFG_PANEL_HEIGHT: panel_h   = cfg_data_i;
          CFG_START_SIZE:   start_sz  = cfg_data_i;
          CFG_ANCHOR_RIGHT: anchor_r  = cfg_data_i[0];
          CFG_OPEN_MODE:    opening   = cfg_data_i[0];
          CFG_OPEN_DUR:     open_dur  = cfg_data_i;
          CFG_CLOSE_DUR:    close_dur = cfg_data_i;
          default: ;
        endcase
      end
      // results leave before a request taken on the same edge can produce one
      if (m_axis_tvalid && m_axis_tready) begin
        got = m_axis_tdata[36:0];
        if (awaited_results.size() == 0) begin
          $display("%0t: unexpected result, expected none got %h", $time, got);
          errors++;
        end else begin
          want = awaited_results.pop_front();
          check_field("out_pixel", want.pixel, got.pixel);
          check_field("window_width", want.width, got.width);
          check_field("window_height", want.height, got.height);
          check_field("finished", want.done, got.done);
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        if (s_axis_tuser == ActFrame)
          awaited_results.push_back(advance_frame(s_axis_tdata[15:0]));
        else
          awaited_results.push_back(composite(s_axis_tdata[25:16], s_axis_tdata[35:26],
                                              s_axis_tdata[51:36], s_axis_tdata[67:52]));
      end
      pending_o  <= awaited_results.size();
      fail_cnt_o <= errors;
    end
  end

endmodule

[sim/rounded_window_reveal_compositor_unit_tb.sv]
`timescale 1ns / 100ps

module rounded_window_reveal_compositor_unit_tb;
  import rwrc_pkg::*;

  localparam int unsigned CornerRadius = 5;
  localparam int unsigned MaxDim       = 1023;
  localparam logic ActFrame = 1'b0;
  localparam logic ActPixel = 1'b1;
  localparam logic [CfgIdxW-1:0] CfgIdxUnused = 3'd7;

  typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_e;

  typedef struct packed {
    logic [9:0] pw;
    logic [9:0] ph;
    logic [9:0] start;
    logic [9:0] anchor;
    logic [9:0] omode;
    logic [9:0] odur;
    logic [9:0] cdur;
  } reveal_cfg_t;

  logic               clk_i;
  logic               rst_ni;
  logic               s_axis_tvalid;
  logic               s_axis_tready;
  logic [71:0]        s_axis_tdata;
  logic               s_axis_tuser;
  logic               m_axis_tvalid;
  logic               m_axis_tready = 1'b1;
  logic [39:0]        m_axis_tdata;
  logic               cfg_valid_i;
  logic               cfg_ready_o;
  logic [CfgIdxW-1:0] cfg_index_i;
  logic [9:0]         cfg_data_i;

  int          pending_cnt, fail_cnt;
  int          send_idle_pct = 0;
  int          rx_stall_pct = 0;
  reveal_cfg_t cur_cfg;

  rounded_window_reveal_compositor_unit #(
    .CORNER_RADIUS(CornerRadius),
    .MAX_DIM      (MaxDim)
  ) u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i)
  );

  rwrc_reveal_checker #(
    .CORNER_RADIUS(CornerRadius),
    .MAX_DIM      (MaxDim)
  ) u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .pending_o    (pending_cnt),
    .fail_cnt_o   (fail_cnt)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #5_000_000;
    $display("rounded_window_reveal_compositor_unit_tb NOT OK");
    $finish;
  end

  always @(posedge clk_i) begin
    m_axis_tready <= (rx_stall_pct == 0) || ($urandom_range(0, 99) >= rx_stall_pct);
  end

  task automatic set_idle(input idle_mode_e mode);
    case (mode)
      IDLE_SEND: begin send_idle_pct = 52; rx_stall_pct = 0; end
      IDLE_RECV: begin send_idle_pct = 0; rx_stall_pct = 52; end
      IDLE_BOTH: begin send_idle_pct = 37; rx_stall_pct = 37; end
      default:   begin send_idle_pct = 0; rx_stall_pct = 0; end
    endcase
  endtask

  task automatic send_req(input logic act, input logic [71:0] data);
    if (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(0, 99) < send_idle_pct);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= act;
    s_axis_tdata  <= data;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  // pixel fields ride along on frame requests and must be ignored
  task automatic send_frame(input logic [15:0] el);
    send_req(ActFrame, {4'b0, 16'($urandom), 16'($urandom), 10'($urandom), 10'($urandom), el});
  endtask

  task automatic send_pixel(input logic [9:0] x, input logic [9:0] y,
                            input logic [15:0] bg, input logic [15:0] fg);
    send_req(ActPixel, {4'b0, fg, bg, y, x, 16'($urandom)});
  endtask

  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending_cnt != 0) @(posedge clk_i);
  endtask

  task automatic cfg_put(input logic [CfgIdxW-1:0] idx, input logic [9:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
  endtask

  task automatic cfg_apply(input reveal_cfg_t c);
    cfg_put(CfgIdxUnused, 10'($urandom));
    cfg_put(CFG_PANEL_WIDTH, c.pw);
    cfg_put(CFG_PANEL_HEIGHT, c.ph);
    cfg_put(CFG_START_SIZE, c.start);
    cfg_put(CFG_ANCHOR_RIGHT, c.anchor);
    cfg_put(CFG_OPEN_MODE, c.omode);
    cfg_put(CFG_OPEN_DUR, c.odur);
    cfg_put(CFG_CLOSE_DUR, c.cdur);
    cfg_valid_i <= 1'b0;
    cur_cfg = c;
  endtask

  function automatic reveal_cfg_t mk_cfg(input int pw, input int ph, input int st, input int an,
                                         input int om, input int od, input int cd);
    reveal_cfg_t c;
    c.pw = 10'(pw); c.ph = 10'(ph); c.start = 10'(st);
    c.anchor = 10'(an); c.omode = 10'(om);
    c.odur = 10'(od); c.cdur = 10'(cd);
    return c;
  endfunction

  function automatic int pick_size();
    case ($urandom_range(0, 9))
      0:       return 1;
      1:       return 1023;
      2:       return 0;
      3, 4, 5, 6, 7: return $urandom_range(6, 48);
      default: return $urandom_range(1, 1023);
    endcase
  endfunction

  function automatic int pick_dur();
    case ($urandom_range(0, 9))
      0:       return 0;
      1:       return 1;
      2:       return 1000;
      3, 4, 5, 6, 7: return $urandom_range(2, 40);
      default: return $urandom_range(1, 1000);
    endcase
  endfunction

  // mostly near the animation span so that the easing curve is swept
  function automatic logic [15:0] pick_elapsed();
    int unsigned dur;
    dur = cur_cfg.omode[0] ? cur_cfg.odur : cur_cfg.cdur;
    if ($urandom_range(0, 7) == 0) return 16'($urandom);
    return 16'($urandom_range(0, dur + 3));
  endfunction

  function automatic logic [9:0] pick_coord(input int unsigned span);
    int unsigned lim;
    if ($urandom_range(0, 9) == 0) return 10'($urandom);
    lim = span + 2;
    if (lim > 1023) lim = 1023;
    return 10'($urandom_range(0, lim));
  endfunction

  task automatic send_rand_pixel();
    logic [9:0] y;
    // top rows hit the rounded corners more often
    if ($urandom_range(0, 3) == 0) y = 10'($urandom_range(0, 7));
    else y = pick_coord(cur_cfg.ph);
    send_pixel(pick_coord(cur_cfg.pw), y, 16'($urandom), 16'($urandom));
  endtask

  // each burst is a frame update followed by a run of pixels
  task automatic run_bursts(input int n_items);
    int sent, run_len;
    sent = 0;
    while (sent < n_items) begin
      if (sent > 0 && $urandom_range(0, 29) == 0) wait_idle();
      send_frame(pick_elapsed());
      sent++;
      run_len = $urandom_range(1, 6);
      for (int k = 0; k < run_len && sent < n_items; k++) begin
        send_rand_pixel();
        sent++;
      end
    end
  endtask

  initial begin
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = 1'b0;
    cfg_valid_i   = 1'b0;
    cfg_index_i   = '0;
    cfg_data_i    = '0;
    cur_cfg = mk_cfg(PANEL_WIDTH_RST, PANEL_HEIGHT_RST, START_SIZE_RST, 0, 1,
                     OPEN_DUR_RST, CLOSE_DUR_RST);
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // register defaults: pixels with the window still at start size, then frames and pixels
    send_pixel(10'd0, 10'd0, 16'h0000, 16'hFFFF);
    send_pixel(10'd5, 10'd0, 16'h0000, 16'hFFFF);
    send_pixel(10'd29, 10'd29, 16'hFFFF, 16'h0000);
    send_frame(16'd0);
    send_frame(16'd150);
    send_pixel(10'd159, 10'd239, 16'h0000, 16'hFFFF);
    send_pixel(10'd1023, 10'd1023, 16'hFFFF, 16'h0000);
    send_pixel(10'd80, 10'd120, 16'h0000, 16'hFFFF);
    send_frame(16'hFFFF);
    send_frame(16'd75);
    send_pixel(10'd1, 10'd3, 16'hFFFF, 16'h0000);
    wait_idle();

    // closing, zero durations, start larger than panel, right anchored
    cfg_apply(mk_cfg(40, 20, 1023, 1, 0, 0, 0));
    send_frame(16'd0);
    send_pixel(10'd0, 10'd0, 16'h0000, 16'hFFFF);
    send_pixel(10'd39, 10'd10, 16'h0000, 16'hFFFF);
    send_pixel(10'd40, 10'd10, 16'h0000, 16'hFFFF);
    send_frame(16'd1);
    wait_idle();

    // zero panel width and zero start size
    cfg_apply(mk_cfg(0, 1023, 0, 2, 1, 1000, 1000));
    send_frame(16'd500);
    send_pixel(10'd0, 10'd0, 16'h0000, 16'hFFFF);
    send_frame(16'd1000);
    send_pixel(10'd0, 10'd1022, 16'h0000, 16'hFFFF);

    for (int ph = 0; ph < 8; ph++) begin
      wait_idle();
      if (ph == 0) cfg_apply(mk_cfg(1023, 1023, 1, 1, 1, 1000, 1));
      else if (ph == 1) cfg_apply(mk_cfg(1, 1, 1023, 0, 0, 1, 1000));
      else cfg_apply(mk_cfg(pick_size(), pick_size(), pick_size(), $urandom_range(0, 1023),
                            $urandom_range(0, 1023), pick_dur(), pick_dur()));
      set_idle(idle_mode_e'(ph % 4));
      run_bursts(50);
    end

    wait_idle();
    set_idle(IDLE_NONE);
    repeat (150) @(posedge clk_i);
    if (pending_cnt != 0)
      $display("%0t: %0d expected results never arrived", $time, pending_cnt);
    if (fail_cnt == 0 && pending_cnt == 0) begin
      $display("rounded_window_reveal_compositor_unit_tb OK");
    end else begin
      $display("rounded_window_reveal_compositor_unit_tb NOT OK");
    end
    $finish;
  end

endmodule

[filelist.f]
src/rwrc_pkg.sv
src/rwrc_div.sv
src/rounded_window_reveal_compositor_unit.sv
sim/rwrc_reveal_checker.sv
sim/rounded_window_reveal_compositor_unit_tb.sv
